// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ETF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ETF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/core/etf_pkg.sv -----
// Types, constants and helpers for the escape-time fractal pixel engine.
// No dependencies.
package etf_pkg;

    localparam int COORD_W   = 10;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 37;   // signed product/sum width after >> 28
    localparam int WIDE_W    = 40;   // headroom for sums before saturation
    localparam int IDX_W     = 3;
    localparam int MAG_W     = 11;   // |3*dx| and |2*dy|
    localparam int DIV_STEPS = 45;   // MAG_W + 34 quotient bits
    localparam int DCNT_W    = 6;
    localparam int COLOUR_W  = 24;

    localparam logic [COORD_W-1:0] HALF_DIM = 10'd512;

    // Q4.28 constants
    localparam logic signed [WORD_W-1:0] JULIA_CR_BASE = -32'sd187904819; // -0.7
    localparam logic signed [WORD_W-1:0] JULIA_CI_BASE = 32'sd72517838;   // 0.27015
    localparam logic signed [WORD_W-1:0] MANDEL_SHIFT  = 32'sd134217728;  // 0.5
    localparam logic [PROD_W:0]          ESC_LIMIT     = 38'd1073741824;  // 4.0
    localparam logic [8:0]               COLOUR_MUL    = 9'd265;

    // register map
    localparam logic [IDX_W-1:0] REG_JULIA_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_ITER   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZOOM       = 3'd2;
    localparam logic [IDX_W-1:0] REG_PAN_RE     = 3'd3;
    localparam logic [IDX_W-1:0] REG_PAN_IM     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CR_DELTA   = 3'd5;
    localparam logic [IDX_W-1:0] REG_CI_DELTA   = 3'd6;

    localparam logic [COORD_W-1:0] MAX_ITER_RST = 10'd150;
    localparam logic [WORD_W-1:0]  ZOOM_RST     = 32'd49152;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_div_req;

    typedef struct packed {
        logic en;
        logic dbl;
    } t_mul_req;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/etf_if.sv -----
// Channel interfaces: pixel in, result out, configuration write.
// Depends on etf_pkg.
interface etf_pix_if;
    logic                        valid;
    logic                        ready;
    logic [etf_pkg::COORD_W-1:0] pixel_col;
    logic [etf_pkg::COORD_W-1:0] pixel_row;
    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface etf_res_if;
    logic                         valid;
    logic                         ready;
    logic [etf_pkg::COORD_W-1:0]  out_col;
    logic [etf_pkg::COORD_W-1:0]  out_row;
    logic [etf_pkg::COORD_W-1:0]  escape_count;
    logic [etf_pkg::COLOUR_W-1:0] pixel_colour;
    modport source (output valid, out_col, out_row, escape_count, pixel_colour, input ready);
    modport sink   (input valid, out_col, out_row, escape_count, pixel_colour, output ready);
endinterface

interface etf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [etf_pkg::IDX_W-1:0]  index;
    logic [etf_pkg::WORD_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/escape_time_fractal_pixel.sv -----
// Escape-time fractal pixel engine, top level: config registers and sequencer.
// Depends on etf_pkg, etf_if, etf_mul, etf_div, assert_macros.svh.
//
// One pixel at a time. The pixel is mapped to the complex plane by a shared
// bit-serial divider (45 quotient bits for each axis), S_INIT then loads z and
// c, and z = z^2 + c is iterated on one shared 32x32 multiplier (three
// products and the update for each step, with an escape check on each
// updated z). The escape count is the number of updates made less one for
// a pixel that escapes, otherwise max_iterations; a max_iterations of zero
// skips the iteration. The result is held until it is taken. The pixel
// input is ready only when the engine is idle. Configuration writes are
// always accepted and must only be made while no pixel is in flight.
`include "assert_macros.svh"

module escape_time_fractal_pixel (
    input  logic i_clk,
    input  logic i_rst_n,
    etf_pix_if.sink   i_pix,
    etf_res_if.source o_res,
    etf_cfg_if.sink   i_cfg
);
    import etf_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DIVR = 10'b0000000010,
        S_DIVI = 10'b0000000100,
        S_INIT = 10'b0000001000,
        S_MRR  = 10'b0000010000,
        S_MII  = 10'b0000100000,
        S_MRI  = 10'b0001000000,
        S_UPD  = 10'b0010000000,
        S_CHK  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                     r_julia;
    logic [COORD_W-1:0]       r_max_iter;
    logic [WORD_W-1:0]        r_zoom;
    logic signed [WORD_W-1:0] r_pan_re, r_pan_im, r_cr_delta, r_ci_delta;

    // datapath
    logic [COORD_W-1:0]       r_col, r_row, r_iter, r_count;
    logic signed [WORD_W-1:0] r_pre, r_pim, r_zr, r_zi, r_cr, r_ci;
    logic signed [PROD_W-1:0] r_sr, r_si;
    logic                     r_first;

    logic                     pix_acc;
    t_div_req                 div_req;
    logic [WORD_W-1:0]        zoom_eff;
    logic                     div_done;
    logic signed [WORD_W-1:0] div_quot;
    logic signed [WORD_W-1:0] mapped;
    logic signed [12:0]       dx3, dy2;

    t_mul_req                 mul_req;
    logic signed [WORD_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_res;

    logic signed [WORD_W-1:0] nr, ni;
    logic [PROD_W:0]          mag2;
    logic                     escaped, last;
    logic [COORD_W:0]         iter_inc;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_julia    <= 1'b1;
            r_max_iter <= MAX_ITER_RST;
            r_zoom     <= ZOOM_RST;
            r_pan_re   <= '0;
            r_pan_im   <= '0;
            r_cr_delta <= '0;
            r_ci_delta <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_JULIA_MODE: r_julia    <= i_cfg.data[0];
                REG_MAX_ITER:   r_max_iter <= i_cfg.data[COORD_W-1:0];
                REG_ZOOM:       r_zoom     <= i_cfg.data;
                REG_PAN_RE:     r_pan_re   <= i_cfg.data;
                REG_PAN_IM:     r_pan_im   <= i_cfg.data;
                REG_CR_DELTA:   r_cr_delta <= i_cfg.data;
                REG_CI_DELTA:   r_ci_delta <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // mapping: numerators 3*(col-512) and 2*(row-512)
    always_comb begin
        dx3 = 13'sd3 * $signed({3'b000, i_pix.pixel_col} - {3'b000, HALF_DIM});
        dy2 = 13'sd2 * $signed({3'b000, r_row} - {3'b000, HALF_DIM});
        div_req = '0;
        if (r_state == S_IDLE) begin
            div_req.start = pix_acc;
            div_req.neg   = dx3[12];
            div_req.mag   = dx3[12] ? MAG_W'(-dx3) : dx3[MAG_W-1:0];
        end else begin
            div_req.start = (r_state == S_DIVR) && div_done;
            div_req.neg   = dy2[12];
            div_req.mag   = dy2[12] ? MAG_W'(-dy2) : dy2[MAG_W-1:0];
        end
        zoom_eff = (r_zoom == '0) ? 32'd1 : r_zoom;
        mapped   = sat_word(WIDE_W'(div_quot)
                   + ((r_state == S_DIVR) ? WIDE_W'(r_pan_re) : WIDE_W'(r_pan_im)));
    end

    etf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_den   (zoom_eff),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // multiplier operand select
    always_comb begin
        mul_req.en  = (r_state == S_MRR) || (r_state == S_MII) || (r_state == S_MRI);
        mul_req.dbl = (r_state == S_MRI);
        mul_a       = (r_state == S_MII) ? r_zi : r_zr;
        mul_b       = (r_state == S_MRR) ? r_zr : r_zi;
    end

    etf_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_res (mul_res)
    );

    // in S_UPD mul_res is 2*zr*zi; in S_CHK it is zi^2
    always_comb begin
        nr       = sat_word(WIDE_W'(r_sr) - WIDE_W'(r_si) + WIDE_W'(r_cr));
        ni       = sat_word(WIDE_W'(mul_res) + WIDE_W'(r_ci));
        mag2     = (PROD_W+1)'(r_sr) + (PROD_W+1)'(mul_res);
        escaped  = mag2 > ESC_LIMIT;
        iter_inc = {1'b0, r_iter} + 1'b1;
        last     = (iter_inc == {1'b0, r_max_iter});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (pix_acc) n_state = S_DIVR;
            S_DIVR: if (div_done) n_state = S_DIVI;
            S_DIVI: if (div_done) n_state = S_INIT;
            S_INIT: n_state = (r_max_iter == '0) ? S_OUT : S_MRR;
            S_MRR:  n_state = S_MII;
            S_MII:  n_state = r_first ? S_MRI : S_CHK;
            S_MRI:  n_state = S_UPD;
            S_UPD:  n_state = S_MRR;
            S_CHK:  n_state = (escaped || last) ? S_OUT : S_MRI;
            S_OUT:  if (o_res.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (pix_acc) begin
                    r_col <= i_pix.pixel_col;
                    r_row <= i_pix.pixel_row;
                end
            end
            S_DIVR: if (div_done) r_pre <= mapped;
            S_DIVI: if (div_done) r_pim <= mapped;
            S_INIT: begin
                r_iter  <= '0;
                r_count <= '0;
                r_first <= 1'b1;
                if (r_julia) begin
                    r_zr <= r_pre;
                    r_zi <= r_pim;
                    r_cr <= sat_word(WIDE_W'(JULIA_CR_BASE) + WIDE_W'(r_cr_delta));
                    r_ci <= sat_word(WIDE_W'(JULIA_CI_BASE) + WIDE_W'(r_ci_delta));
                end else begin
                    r_zr <= '0;
                    r_zi <= '0;
                    r_cr <= sat_word(WIDE_W'(r_pre) - WIDE_W'(MANDEL_SHIFT));
                    r_ci <= r_pim;
                end
            end
            S_MII: r_sr <= mul_res;
            S_MRI: r_si <= mul_res;
            S_UPD: begin
                r_zr    <= nr;
                r_zi    <= ni;
                r_first <= 1'b0;
            end
            S_CHK: begin
                if (escaped) begin
                    r_count <= r_iter;
                end else begin
                    r_iter  <= iter_inc[COORD_W-1:0];
                    r_count <= iter_inc[COORD_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid        = (r_state == S_OUT);
    assign o_res.out_col      = r_col;
    assign o_res.out_row      = r_row;
    assign o_res.escape_count = r_count;
    assign o_res.pixel_colour = COLOUR_W'(r_count) * COLOUR_W'(COLOUR_MUL);

    `ETF_ASSERT_IMP(a_ready_excl, i_clk, i_rst_n, i_pix.ready, !o_res.valid)
    `ETF_ASSERT_IMP(a_count_lim, i_clk, i_rst_n, o_res.valid, o_res.escape_count <= r_max_iter)
    `ETF_ASSERT_IMP(a_div_start, i_clk, i_rst_n, div_req.start,
                    (r_state == S_IDLE) || (r_state == S_DIVR))
    `ETF_ASSERT_NXT(a_acc_map, i_clk, i_rst_n, pix_acc, r_state == S_DIVR)

endmodule

// ----- rtl/core/etf_mul.sv -----
// Shared fixed-point multiplier: |a|*|b| >> 28, optional doubling and sign.
// Depends on etf_pkg.
module etf_mul (
    input  logic                               i_clk,
    input  etf_pkg::t_mul_req                  i_req,
    input  logic signed [etf_pkg::WORD_W-1:0]  i_a,
    input  logic signed [etf_pkg::WORD_W-1:0]  i_b,
    output logic signed [etf_pkg::PROD_W-1:0]  o_res
);
    import etf_pkg::*;

    logic [WORD_W-1:0]        ma, mb;
    logic [2*WORD_W-1:0]      prod;
    logic [PROD_W-2:0]        trunc;
    logic                     neg;
    logic signed [PROD_W-1:0] n_res;
    logic signed [PROD_W-1:0] r_res;

    always_comb begin
        ma    = i_a[WORD_W-1] ? (~i_a + 32'd1) : i_a;
        mb    = i_b[WORD_W-1] ? (~i_b + 32'd1) : i_b;
        prod  = ma * mb;
        // doubling folds into the slice: (p << 1) >> 28
        trunc = i_req.dbl ? prod[62:27] : prod[63:28];
        neg   = i_req.dbl & (i_a[WORD_W-1] ^ i_b[WORD_W-1]);
        n_res = neg ? -$signed({1'b0, trunc}) : $signed({1'b0, trunc});
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/core/etf_div.sv -----
// Restoring divider for pixel mapping: sat(sign * |num| * 2^34 / zoom).
// Depends on etf_pkg; one quotient bit per cycle.
module etf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  etf_pkg::t_div_req                 i_req,
    input  logic [etf_pkg::WORD_W-1:0]        i_den,
    output logic                              o_done,
    output logic signed [etf_pkg::WORD_W-1:0] o_quot
);
    import etf_pkg::*;

    logic                    r_busy, r_done, r_neg;
    logic [DCNT_W-1:0]       r_cnt;
    logic [WORD_W-1:0]       r_rem;
    logic [DIV_STEPS-1:0]    r_dvd;
    logic [DIV_STEPS-1:0]    r_quo;
    logic [WORD_W:0]         rem_sh;
    logic [WORD_W+1:0]       diff;
    logic                    qbit;

    always_comb begin
        rem_sh = {r_rem, r_dvd[DIV_STEPS-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_den};
        qbit   = ~diff[WORD_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_neg <= i_req.neg;
            r_dvd <= {i_req.mag, {(DIV_STEPS - MAG_W){1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= qbit ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            r_dvd <= {r_dvd[DIV_STEPS-2:0], 1'b0};
            r_quo <= {r_quo[DIV_STEPS-2:0], qbit};
        end
    end

    // clamp to the signed word
    always_comb begin
        if (|r_quo[DIV_STEPS-1:WORD_W-1]) begin
            o_quot = r_neg ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            o_quot = r_neg ? -$signed(r_quo[WORD_W-1:0]) : $signed(r_quo[WORD_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule
